>>> rtl/tlhr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlhr_pkg: shared types and constants of the two-level hash registry
// Holds command and status codes, register indexes, widths and the FSM type.
// ----------------------------------------------------------------------------
package tlhr_pkg;

    localparam int DEF_TYPE_SLOTS   = 64;
    localparam int DEF_SUBMAP_SLOTS = 16;
    localparam int DEF_POOL_SUBMAPS = 64;

    localparam int HASH_W  = 64;
    localparam int PTR_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_W   = 9;     // divisor and remainder width (up to 511)
    localparam int DIV_BITS = 8;    // dividend bits retired per cycle

    localparam logic [CMD_W-1:0] CMD_PUT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET_ANY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_MASTER_FULL = 3'd1;
    localparam logic [STAT_W-1:0] ST_POOL_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_SUBMAP_FULL = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TYPE_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBMAP_BUDGET = 1'd1;

    localparam logic [CFG_W-1:0] RST_TYPE_CAPACITY = 7'd64;
    localparam logic [CFG_W-1:0] RST_SUBMAP_BUDGET = 7'd64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TDIV,
        S_TPROBE,
        S_TCMP,
        S_MREQ,
        S_MGET,
        S_NDIV,
        S_NPROBE,
        S_NCMP,
        S_AGET,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

>>> rtl/tlhr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlhr_ram: simple dual-port synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module tlhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/tlhr_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlhr_mod: iterative remainder unit
// Reduces a 64-bit hash modulo a small divisor, DIV_BITS bits per cycle.
// ----------------------------------------------------------------------------
module tlhr_mod
    import tlhr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic      [DIV_W-1:0]  o_rem
);

    localparam int STEPS = HASH_W / DIV_BITS;
    localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic              r_busy;
    logic              r_done;
    logic [SCW-1:0]    r_cnt;
    logic [HASH_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  n_rem;

    // restoring remainder over the top DIV_BITS dividend bits
    always_comb begin
        logic [DIV_W:0] t;
        t = '0;
        n_rem = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {n_rem, r_dvd[HASH_W-1-i]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (32'(r_cnt) == STEPS - 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << DIV_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/two_level_hash_registry_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_hash_registry_top: two-level linear-probing hash registry
// Master table of types, each owning a sub-map of name entries from a pool.
// ----------------------------------------------------------------------------
// The block takes one command at a time. An item first reduces type_hash
// modulo the effective type capacity in the shared remainder unit. It then
// probes the master table; an occupied slot adds a key RAM read and compare.
// After the type resolves, the sub-map's occupancy mask is read. A put or get
// starts the reduction of name_hash modulo SUBMAP_SLOTS with the mask read and
// waits for it. It then probes the sub-map the same way. A get-any reads the
// lowest occupied entry directly. The result register is then loaded. A
// finished result waits in the output register while the next command is
// taken. Sub-map occupancy masks are zeroed when a sub-map is handed out, so
// no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module two_level_hash_registry_top
    import tlhr_pkg::*;
#(
    parameter int TYPE_SLOTS   = DEF_TYPE_SLOTS,
    parameter int SUBMAP_SLOTS = DEF_SUBMAP_SLOTS,
    parameter int POOL_SUBMAPS = DEF_POOL_SUBMAPS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    // command channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [HASH_W-1:0]    i_type_hash,
    input  wire logic [HASH_W-1:0]    i_name_hash,
    input  wire logic [PTR_W-1:0]     i_entry_pointer,
    input  wire logic [SIZE_W-1:0]    i_entry_size,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [STAT_W-1:0]    o_status,
    output logic      [PTR_W-1:0]     o_found_pointer,
    output logic      [SIZE_W-1:0]    o_found_size
);

    localparam int TW  = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
    localparam int NW  = (SUBMAP_SLOTS > 1) ? $clog2(SUBMAP_SLOTS) : 1;
    localparam int NCW = $clog2(SUBMAP_SLOTS + 1);
    localparam int PW  = (POOL_SUBMAPS > 1) ? $clog2(POOL_SUBMAPS) : 1;
    localparam int CW  = $clog2(POOL_SUBMAPS + 1);
    localparam int TOTAL = POOL_SUBMAPS * SUBMAP_SLOTS;
    localparam int SW  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int TDW = HASH_W + PW;
    localparam int SDW = HASH_W + PTR_W + SIZE_W;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_type_capacity;
    logic [CFG_W-1:0] r_submap_budget;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_capacity <= RST_TYPE_CAPACITY;
            r_submap_budget <= RST_SUBMAP_BUDGET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TYPE_CAPACITY: r_type_capacity <= i_cfg_wdata;
                REG_SUBMAP_BUDGET: r_submap_budget <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp capacity to 1..TYPE_SLOTS and budget to POOL_SUBMAPS
    logic [CFG_W-1:0] w_cap;
    logic [CFG_W-1:0] w_budget;

    always_comb begin
        if (r_type_capacity == '0) begin
            w_cap = CFG_W'(1);
        end else if (32'(r_type_capacity) > TYPE_SLOTS) begin
            w_cap = CFG_W'(TYPE_SLOTS);
        end else begin
            w_cap = r_type_capacity;
        end
        if (32'(r_submap_budget) > POOL_SUBMAPS) begin
            w_budget = CFG_W'(POOL_SUBMAPS);
        end else begin
            w_budget = r_submap_budget;
        end
    end

    // ---------------- working registers ----------------
    t_state            r_state;
    t_state            n_state;
    logic [CMD_W-1:0]  r_cmd;
    logic [HASH_W-1:0] r_th;
    logic [HASH_W-1:0] r_nh;
    logic [PTR_W-1:0]  r_ptr;
    logic [SIZE_W-1:0] r_sz;
    logic [STAT_W-1:0] r_status;
    logic [PTR_W-1:0]  r_rp;
    logic [SIZE_W-1:0] r_rs;
    logic [TW-1:0]     r_tidx;
    logic [CFG_W-1:0]  r_tcnt;
    logic [NW-1:0]     r_nidx;
    logic [NCW-1:0]    r_ncnt;
    logic [PW-1:0]     r_sub;
    logic [SUBMAP_SLOTS-1:0] r_mask;
    logic [CW-1:0]     r_taken;
    logic [TYPE_SLOTS-1:0] r_type_used;

    logic              r_ov;
    logic [STAT_W-1:0] r_o_status;
    logic [PTR_W-1:0]  r_o_ptr;
    logic [SIZE_W-1:0] r_o_size;

    // ---------------- remainder unit ----------------
    logic              w_div_start;
    logic [HASH_W-1:0] w_div_dvd;
    logic [DIV_W-1:0]  w_div_dsr;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_div_rem;

    tlhr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // ---------------- memories ----------------
    logic           w_tm_we;
    logic           w_tm_re;
    logic [TDW-1:0] w_tm_rdata;
    logic [HASH_W-1:0] w_tm_key;
    logic [PW-1:0]  w_tm_sub;

    tlhr_ram #(.WIDTH(TDW), .DEPTH(TYPE_SLOTS), .AW(TW)) u_type_ram (
        .i_clk   (i_clk),
        .i_we    (w_tm_we),
        .i_waddr (r_tidx),
        .i_wdata ({r_th, PW'(r_taken)}),
        .i_re    (w_tm_re),
        .i_raddr (r_tidx),
        .o_rdata (w_tm_rdata)
    );

    assign w_tm_key = w_tm_rdata[TDW-1:PW];
    assign w_tm_sub = w_tm_rdata[PW-1:0];

    logic                    w_mm_we;
    logic [PW-1:0]           w_mm_waddr;
    logic [SUBMAP_SLOTS-1:0] w_mm_wdata;
    logic                    w_mm_re;
    logic [SUBMAP_SLOTS-1:0] w_mm_rdata;

    tlhr_ram #(.WIDTH(SUBMAP_SLOTS), .DEPTH(POOL_SUBMAPS), .AW(PW)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (w_mm_we),
        .i_waddr (w_mm_waddr),
        .i_wdata (w_mm_wdata),
        .i_re    (w_mm_re),
        .i_raddr (r_sub),
        .o_rdata (w_mm_rdata)
    );

    logic           w_sm_we;
    logic           w_sm_re;
    logic [SW-1:0]  w_sm_waddr;
    logic [SW-1:0]  w_sm_raddr;
    logic [SDW-1:0] w_sm_rdata;
    logic [HASH_W-1:0] w_sm_key;
    logic [PTR_W-1:0]  w_sm_ptr;
    logic [SIZE_W-1:0] w_sm_size;

    tlhr_ram #(.WIDTH(SDW), .DEPTH(TOTAL), .AW(SW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_sm_we),
        .i_waddr (w_sm_waddr),
        .i_wdata ({r_nh, r_ptr, r_sz}),
        .i_re    (w_sm_re),
        .i_raddr (w_sm_raddr),
        .o_rdata (w_sm_rdata)
    );

    assign w_sm_key  = w_sm_rdata[SDW-1:PTR_W+SIZE_W];
    assign w_sm_ptr  = w_sm_rdata[PTR_W+SIZE_W-1:SIZE_W];
    assign w_sm_size = w_sm_rdata[SIZE_W-1:0];

    // ---------------- decision terms ----------------
    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_tfree;
    logic                    w_pool_ok;
    logic                    w_tkey_hit;
    logic                    w_tlast;
    logic [TW-1:0]           w_tnext;
    logic                    w_nfree;
    logic                    w_nkey_hit;
    logic                    w_nlast;
    logic [NW-1:0]           w_nnext;
    logic [SW-1:0]           w_slot_addr;
    logic [NW-1:0]           w_lowest;
    logic [SUBMAP_SLOTS-1:0] w_mask_set;
    logic                    w_known_cmd;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;
    assign w_tfree    = !r_type_used[r_tidx];
    assign w_pool_ok  = 32'(r_taken) < 32'(w_budget);
    assign w_tkey_hit = (w_tm_key == r_th);
    assign w_tlast    = (32'(r_tcnt) + 1 == 32'(w_cap));
    assign w_tnext    = (32'(r_tidx) + 1 == 32'(w_cap)) ? '0 : r_tidx + 1'b1;
    assign w_nfree    = !r_mask[r_nidx];
    assign w_nkey_hit = (w_sm_key == r_nh);
    assign w_nlast    = (32'(r_ncnt) + 1 == SUBMAP_SLOTS);
    assign w_nnext    = (32'(r_nidx) + 1 == SUBMAP_SLOTS) ? '0 : r_nidx + 1'b1;
    assign w_slot_addr = SW'(32'(r_sub) * SUBMAP_SLOTS + 32'(r_nidx));
    assign w_known_cmd = (i_command == CMD_PUT) || (i_command == CMD_GET) ||
                         (i_command == CMD_GET_ANY);

    always_comb begin
        w_lowest = '0;
        for (int i = SUBMAP_SLOTS - 1; i >= 0; i--) begin
            if (w_mm_rdata[i]) begin
                w_lowest = NW'(i);
            end
        end
        w_mask_set = r_mask;
        w_mask_set[r_nidx] = 1'b1;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_known_cmd ? S_TDIV : S_RESP;
                end
            end
            S_TDIV: begin
                if (w_div_done) begin
                    n_state = S_TPROBE;
                end
            end
            S_TPROBE: begin
                if (!w_tfree) begin
                    n_state = S_TCMP;
                end else if (r_cmd == CMD_PUT && w_pool_ok) begin
                    n_state = S_MREQ;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_TCMP: begin
                if (w_tkey_hit) begin
                    n_state = S_MREQ;
                end else if (w_tlast) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_TPROBE;
                end
            end
            S_MREQ: n_state = S_MGET;
            S_MGET: begin
                if (r_cmd == CMD_GET_ANY) begin
                    n_state = (w_mm_rdata == '0) ? S_RESP : S_AGET;
                end else begin
                    n_state = S_NDIV;
                end
            end
            S_NDIV: begin
                if (w_div_done) begin
                    n_state = S_NPROBE;
                end
            end
            S_NPROBE: n_state = w_nfree ? S_RESP : S_NCMP;
            S_NCMP: begin
                if (w_nkey_hit || w_nlast) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_NPROBE;
                end
            end
            S_AGET: n_state = S_RESP;
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_div_dvd   = r_th;
        w_div_dsr   = DIV_W'(w_cap);
        w_tm_we     = 1'b0;
        w_tm_re     = 1'b0;
        w_mm_we     = 1'b0;
        w_mm_waddr  = r_sub;
        w_mm_wdata  = w_mask_set;
        w_mm_re     = 1'b0;
        w_sm_we     = 1'b0;
        w_sm_re     = 1'b0;
        w_sm_waddr  = w_slot_addr;
        w_sm_raddr  = w_slot_addr;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                w_div_start = w_in_xfer && w_known_cmd;
                w_div_dvd   = i_type_hash;
            end
            S_TPROBE: begin
                w_tm_re = !w_tfree;
                // new type: claim the slot and hand out an empty sub-map
                if (w_tfree && r_cmd == CMD_PUT && w_pool_ok) begin
                    w_tm_we    = 1'b1;
                    w_mm_we    = 1'b1;
                    w_mm_waddr = PW'(r_taken);
                    w_mm_wdata = '0;
                end
            end
            S_MREQ: begin
                w_mm_re     = 1'b1;
                w_div_start = (r_cmd != CMD_GET_ANY);
                w_div_dvd   = r_nh;
                w_div_dsr   = DIV_W'(SUBMAP_SLOTS);
            end
            S_MGET: begin
                w_sm_re    = (r_cmd == CMD_GET_ANY) && (w_mm_rdata != '0);
                w_sm_raddr = SW'(32'(r_sub) * SUBMAP_SLOTS + 32'(w_lowest));
            end
            S_NPROBE: begin
                w_sm_re = !w_nfree;
                if (w_nfree && r_cmd == CMD_PUT) begin
                    w_sm_we = 1'b1;
                    w_mm_we = 1'b1;
                end
            end
            S_NCMP: begin
                w_sm_we = w_nkey_hit && (r_cmd == CMD_PUT);
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_type_used <= '0;
            r_taken     <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new result replaces the one leaving in the same cycle
            if (r_state == S_RESP && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_TPROBE && w_tfree && r_cmd == CMD_PUT && w_pool_ok) begin
                r_type_used[r_tidx] <= 1'b1;
                r_taken <= r_taken + 1'b1;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // latch the command; assume a miss until a lookup lands
                r_cmd    <= i_command;
                r_th     <= i_type_hash;
                r_nh     <= i_name_hash;
                r_ptr    <= i_entry_pointer;
                r_sz     <= i_entry_size;
                r_status <= ST_NOT_FOUND;
                r_rp     <= '0;
                r_rs     <= '0;
                r_tcnt   <= '0;
            end
            S_TDIV: begin
                r_tidx <= TW'(w_div_rem);
            end
            S_TPROBE: begin
                if (w_tfree && r_cmd == CMD_PUT) begin
                    r_status <= w_pool_ok ? ST_OK : ST_POOL_EMPTY;
                    r_sub    <= PW'(r_taken);
                end
            end
            S_TCMP: begin
                r_sub <= w_tm_sub;
                if (!w_tkey_hit) begin
                    r_tidx <= w_tnext;
                    r_tcnt <= r_tcnt + 1'b1;
                    if (w_tlast && r_cmd == CMD_PUT) begin
                        r_status <= ST_MASTER_FULL;
                    end
                end
            end
            S_MGET: begin
                r_mask <= w_mm_rdata;
                r_ncnt <= '0;
            end
            S_NDIV: begin
                r_nidx <= NW'(w_div_rem);
            end
            S_NPROBE: begin
                if (w_nfree) begin
                    r_status <= (r_cmd == CMD_PUT) ? ST_OK : ST_NOT_FOUND;
                end
            end
            S_NCMP: begin
                if (w_nkey_hit) begin
                    r_status <= ST_OK;
                    if (r_cmd == CMD_GET) begin
                        r_rp <= w_sm_ptr;
                        r_rs <= w_sm_size;
                    end
                end else begin
                    r_nidx <= w_nnext;
                    r_ncnt <= r_ncnt + 1'b1;
                    if (w_nlast) begin
                        r_status <= (r_cmd == CMD_PUT) ? ST_SUBMAP_FULL : ST_NOT_FOUND;
                    end
                end
            end
            S_AGET: begin
                r_status <= ST_OK;
                r_rp     <= w_sm_ptr;
                r_rs     <= w_sm_size;
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && w_out_free) begin
            r_o_status <= r_status;
            r_o_ptr    <= r_rp;
            r_o_size   <= r_rs;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_found_pointer = r_o_ptr;
    assign o_found_size    = r_o_size;

endmodule

`default_nettype wire

>>> tb/sv/tlhr_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlhr_scoreboard: registry predictor and result checker
// Watches configuration writes and both channels and keeps its own copy of the
// master table and sub-map pool. It predicts one result per accepted command
// and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tlhr_scoreboard
    import tlhr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [HASH_W-1:0]    i_type_hash,
    input  wire logic [HASH_W-1:0]    i_name_hash,
    input  wire logic [PTR_W-1:0]     i_entry_pointer,
    input  wire logic [SIZE_W-1:0]    i_entry_size,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic [STAT_W-1:0]    i_status,
    input  wire logic [PTR_W-1:0]     i_found_pointer,
    input  wire logic [SIZE_W-1:0]    i_found_size,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int NT = DEF_TYPE_SLOTS;
    localparam int NS = DEF_SUBMAP_SLOTS;
    localparam int NP = DEF_POOL_SUBMAPS;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PTR_W-1:0]  pointer;
        logic [SIZE_W-1:0] size;
    } t_lookup;

    logic [CFG_W-1:0]  capacity_reg, budget_reg;
    bit                type_used [NT];
    logic [HASH_W-1:0] type_key [NT];
    int                type_map [NT];
    int                maps_taken;
    bit                slot_used [NP*NS];
    logic [HASH_W-1:0] slot_key [NP*NS];
    logic [PTR_W-1:0]  slot_ptr [NP*NS];
    logic [SIZE_W-1:0] slot_size [NP*NS];

    t_lookup expected_results [$];

    function automatic int probe_master(input logic [HASH_W-1:0] key, output bit hit);
        int cap, start, idx;
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > NT) ? NT : int'(capacity_reg);
        start = int'(key % cap);
        idx = start;
        hit = 0;
        do begin
            if (!type_used[idx]) return idx;
            if (type_key[idx] == key) begin
                hit = 1;
                return idx;
            end
            idx = (idx + 1) % cap;
        end while (idx != start);
        return -1;
    endfunction

    function automatic int probe_submap(input int base, input logic [HASH_W-1:0] key,
                                        output bit hit);
        int start, idx;
        start = int'(key % NS);
        idx = start;
        hit = 0;
        do begin
            if (!slot_used[base + idx]) return idx;
            if (slot_key[base + idx] == key) begin
                hit = 1;
                return idx;
            end
            idx = (idx + 1) % NS;
        end while (idx != start);
        return -1;
    endfunction

    // Apply one command to the shadow registry and return its answer.
    function automatic t_lookup registry_lookup(input logic [CMD_W-1:0] cmd,
                                                input logic [HASH_W-1:0] th,
                                                input logic [HASH_W-1:0] nh,
                                                input logic [PTR_W-1:0] ptr,
                                                input logic [SIZE_W-1:0] sz);
        t_lookup r;
        bit hit;
        int t, n, base, budget;
        r = '{status: ST_NOT_FOUND, pointer: '0, size: '0};
        budget = (budget_reg > NP) ? NP : int'(budget_reg);
        if (cmd == CMD_PUT) begin
            t = probe_master(th, hit);
            if (t < 0) begin
                r.status = ST_MASTER_FULL;
            end else if (!hit && maps_taken >= budget) begin
                r.status = ST_POOL_EMPTY;
            end else begin
                if (!hit) begin
                    type_used[t] = 1;
                    type_key[t] = th;
                    type_map[t] = maps_taken;
                    maps_taken++;
                end
                base = type_map[t] * NS;
                n = probe_submap(base, nh, hit);
                if (n < 0) begin
                    r.status = ST_SUBMAP_FULL;
                end else begin
                    slot_used[base + n] = 1;
                    slot_key[base + n] = nh;
                    slot_ptr[base + n] = ptr;
                    slot_size[base + n] = sz;
                    r.status = ST_OK;
                end
            end
        end else if (cmd == CMD_GET || cmd == CMD_GET_ANY) begin
            t = probe_master(th, hit);
            if (t >= 0 && hit) begin
                base = type_map[t] * NS;
                if (cmd == CMD_GET) begin
                    n = probe_submap(base, nh, hit);
                    if (n >= 0 && hit)
                        r = '{status: ST_OK, pointer: slot_ptr[base + n],
                              size: slot_size[base + n]};
                end else begin
                    for (int i = 0; i < NS; i++) begin
                        if (slot_used[base + i]) begin
                            r = '{status: ST_OK, pointer: slot_ptr[base + i],
                                  size: slot_size[base + i]};
                            break;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup exp_r;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            capacity_reg <= RST_TYPE_CAPACITY;
            budget_reg   <= RST_SUBMAP_BUDGET;
            maps_taken = 0;
            for (int i = 0; i < NT; i++) type_used[i] = 0;
            for (int i = 0; i < NP*NS; i++) slot_used[i] = 0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TYPE_CAPACITY) capacity_reg <= i_cfg_wdata;
                else if (i_cfg_index == REG_SUBMAP_BUDGET) budget_reg <= i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(registry_lookup(i_command, i_type_hash,
                    i_name_hash, i_entry_pointer, i_entry_size));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, i_status);
                        errs++;
                    end
                    if (i_found_pointer !== exp_r.pointer) begin
                        $error("found_pointer: expected %h, got %h",
                               exp_r.pointer, i_found_pointer);
                        errs++;
                    end
                    if (i_found_size !== exp_r.size) begin
                        $error("found_size: expected %h, got %h", exp_r.size, i_found_size);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_results.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the two-level hash registry
// Runs directed and random commands over several register settings with
// random gaps on both channels; the scoreboard predicts and checks results.
// ----------------------------------------------------------------------------
module tb;
    import tlhr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;   // covers the longest probe chain
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;   // no such command

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command;
    logic [HASH_W-1:0]    i_type_hash;
    logic [HASH_W-1:0]    i_name_hash;
    logic [PTR_W-1:0]     i_entry_pointer;
    logic [SIZE_W-1:0]    i_entry_size;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [STAT_W-1:0]    o_status;
    logic [PTR_W-1:0]     o_found_pointer;
    logic [SIZE_W-1:0]    o_found_size;

    int  fail_count;
    int  pending;
    int  cycle_count;
    int  commands_sent;
    int  settings_run;
    bit  hold_results;     // ask the result side for one long stall

    logic [HASH_W-1:0] type_pool [16];
    logic [HASH_W-1:0] name_pool [24];

    two_level_hash_registry_top dut (.*);

    tlhr_scoreboard scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_command, .i_type_hash,
        .i_name_hash, .i_entry_pointer, .i_entry_size,
        .i_out_valid(o_out_valid), .i_out_ready, .i_status(o_status),
        .i_found_pointer(o_found_pointer), .i_found_size(o_found_size),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_results = 0;
                i_out_ready <= 1'b1;
            end else if (($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0)) begin
                i_out_ready <= 1'b0;
                repeat (random_gap()) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one command and hold it until the transfer.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] th,
                                input logic [HASH_W-1:0] nh, input logic [PTR_W-1:0] ptr,
                                input logic [SIZE_W-1:0] sz, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command       <= cmd;
        i_type_hash     <= th;
        i_name_hash     <= nh;
        i_entry_pointer <= ptr;
        i_entry_size    <= sz;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        commands_sent++;
    endtask

    // Drain all results, then leave the block idle before a register write.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_command(input int gap);
        logic [CMD_W-1:0]  cmd;
        logic [HASH_W-1:0] th, nh;
        int roll;
        roll = $urandom_range(0, 99);
        cmd = (roll < 45) ? CMD_PUT : (roll < 72) ? CMD_GET :
              (roll < 95) ? CMD_GET_ANY : CMD_UNUSED;
        // Mostly known keys so that gets hit and sub-maps fill up.
        th = ($urandom_range(0, 19) == 0) ? rand64() : type_pool[$urandom_range(0, 15)];
        nh = ($urandom_range(0, 9) == 0) ? rand64() : name_pool[$urandom_range(0, 23)];
        send_command(cmd, th, nh, rand64(), $urandom(), gap);
    endtask

    logic [CFG_W-1:0] cap_steps [7] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd3};
    logic [CFG_W-1:0] bud_steps [7] = '{7'd64, 7'd64, 7'd127, 7'd0, 7'd64, 7'd5, 7'd64};

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_command = '0;
        i_type_hash = '0;
        i_name_hash = '0;
        i_entry_pointer = '0;
        i_entry_size = '0;
        cycle_count = 0;
        commands_sent = 0;
        settings_run = 0;
        hold_results = 0;
        foreach (type_pool[i]) type_pool[i] = rand64();
        foreach (name_pool[i]) name_pool[i] = rand64();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every command, overwrite and misses.
        send_command(CMD_PUT, '0, '0, '1, '1, 0);
        send_command(CMD_PUT, '1, '1, '0, '0, 0);
        send_command(CMD_GET, '0, '0, '0, '0, 0);
        send_command(CMD_GET, '1, '1, '0, '0, 0);
        send_command(CMD_GET_ANY, '1, '0, '0, '0, 0);
        send_command(CMD_PUT, '0, '0, 64'h0123_4567_89AB_CDEF, 32'hA5A5_5A5A, 1);
        send_command(CMD_GET, '0, '0, '0, '0, 0);
        send_command(CMD_GET, '0, 64'd77, '0, '0, 0);       // name missing
        send_command(CMD_GET, 64'd12345, '0, '0, '0, 0);    // type missing
        send_command(CMD_GET_ANY, 64'd12345, '0, '0, '0, 0);
        send_command(CMD_UNUSED, '1, '1, '1, '1, 0);        // unknown command
        // Fill one sub-map past its slot count.
        for (int i = 0; i < 17; i++)
            send_command(CMD_PUT, type_pool[0], name_pool[i], rand64(), $urandom(), 0);

        foreach (cap_steps[s]) begin
            drain_and_settle();
            write_reg(REG_TYPE_CAPACITY, cap_steps[s]);
            write_reg(REG_SUBMAP_BUDGET, bud_steps[s]);
            settings_run++;
            if (s == 1) hold_results = 1;   // block fills up and stalls input
            for (int i = 0; i < 107; i++)
                random_command(($urandom_range(0, 9) < 3) ? 0 : random_gap());
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d commands over %0d register settings,", commands_sent, settings_run);
        $display("with random gaps on both channels and one long result stall.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
